// File: rtl/residual_norm_reducer_macros.svh
// Assertion macros for the residual norm reducer.
// Included by the top level; expects signals clk and rst_n in scope.
`ifndef RESIDUAL_NORM_REDUCER_MACROS_SVH
`define RESIDUAL_NORM_REDUCER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RNR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RNR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rnr_pkg.sv
// Shared types, constants and helper functions for the residual norm reducer.
// No dependencies; imported by every module of the block.
package rnr_pkg;

  localparam int VAL_W     = 32;
  localparam int NODE_W    = 16;
  localparam int EQ_W      = 3;
  localparam int EQS_W     = 4;
  localparam int TN_W      = 24;
  localparam int MAX_EQS   = 8;
  localparam int SUM_W     = 64;
  localparam int DVS_W     = 27;
  localparam int DREM_W    = DVS_W + 1;
  localparam int ROOT_W    = 32;
  localparam int SREM_W    = ROOT_W + 3;
  localparam int DIV_STEPS = SUM_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int CNT_W     = 6;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW   = 1;
  localparam int FIFO_CW   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_EQS_PER_NODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_NODES  = 1'd1;

  typedef struct packed {
    logic signed [VAL_W-1:0] resid_value;
    logic signed [VAL_W-1:0] incr_value;
    logic                    node_included;
    logic                    resid_invalid;
    logic                    last_entry;
  } rnr_in_t;

  typedef struct packed {
    logic [VAL_W-1:0]  max_resid;
    logic [NODE_W-1:0] max_resid_node;
    logic [VAL_W-1:0]  max_incr;
    logic [NODE_W-1:0] max_incr_node;
    logic [ROOT_W-1:0] rms_resid;
    logic              invalid_seen;
    logic              sum_saturated;
  } rnr_out_t;

  // One classified word as it travels from the front end to the accumulator.
  typedef struct packed {
    logic [VAL_W-1:0]  ares;
    logic [VAL_W-1:0]  ainc;
    logic [NODE_W-1:0] node;
    logic              incl;
    logic              bad;
    logic              last;
  } rnr_item_t;

  typedef struct packed {
    logic calc;
    logic pop;
  } rnr_bk_stat_t;

  typedef enum logic [2:0] {
    BK_ACC,
    BK_FLUSH,
    BK_LATCH,
    BK_CALC,
    BK_EMIT
  } rnr_bk_state_t;

  typedef enum logic [1:0] {
    FU_IDLE,
    FU_DIV,
    FU_ROOT
  } rnr_fu_state_t;

  // Entries per node as actually used: zero counts as one, large values clamp.
  function automatic logic [EQS_W-1:0] eff_eqs(input logic [EQS_W-1:0] v);
    logic [EQS_W-1:0] r;
    if (v == '0) begin
      r = EQS_W'(1);
    end else if (v > EQS_W'(MAX_EQS)) begin
      r = EQS_W'(MAX_EQS);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/residual_norm_reducer.sv
// Residual norm reducer top level: configuration registers, front end, queue,
// accumulator and finishing unit. One word per cycle while accumulating; after a
// last word the accumulator pauses for the divide and root (longer if the prior
// result waits) and in_ready drops once the two-entry queue fills. The result is
// valid once the 64-step divide and 32-step root finish. rst_n: synchronous, active
// low; clears state and flags but not data registers; config to 1. Uses rnr_pkg.
`include "residual_norm_reducer_macros.svh"

module residual_norm_reducer import rnr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rnr_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rnr_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata
);

  logic [EQS_W-1:0]  eqs_per_node_r;
  logic [TN_W-1:0]   total_nodes_r;
  logic              push, fifo_full, fifo_empty, pop;
  rnr_item_t         push_item, head;
  logic              fin_start, fin_busy, fin_done;
  logic [SUM_W-1:0]  fin_dividend;
  logic [DVS_W-1:0]  fin_divisor;
  logic [ROOT_W-1:0] fin_root;
  rnr_bk_stat_t      bk_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eqs_per_node_r <= EQS_W'(1);
      total_nodes_r  <= TN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EQS_PER_NODE: eqs_per_node_r <= cfg_wdata[EQS_W-1:0];
        CFG_TOTAL_NODES:  total_nodes_r  <= cfg_wdata[TN_W-1:0];
        default:          eqs_per_node_r <= eqs_per_node_r;
      endcase
    end
  end

  rnr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .eqs_per_node (eqs_per_node_r),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_item    (push_item)
  );

  rnr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (fifo_full),
    .pop       (pop),
    .head      (head),
    .empty     (fifo_empty)
  );

  rnr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .empty        (fifo_empty),
    .pop          (pop),
    .eqs_per_node (eqs_per_node_r),
    .total_nodes  (total_nodes_r),
    .fin_start    (fin_start),
    .fin_dividend (fin_dividend),
    .fin_divisor  (fin_divisor),
    .fin_done     (fin_done),
    .fin_root     (fin_root),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .stat         (bk_stat)
  );

  rnr_finish u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (fin_start),
    .dividend (fin_dividend),
    .divisor  (fin_divisor),
    .busy     (fin_busy),
    .done     (fin_done),
    .root     (fin_root)
  );

  `RNR_ASSERT_NOW(a_pop_not_empty, bk_stat.pop, !fifo_empty, "pop from an empty queue")
  `RNR_ASSERT_NOW(a_start_idle, fin_start, !fin_busy, "finishing unit started while busy")
  `RNR_ASSERT_NEXT(a_start_busy, fin_start, fin_busy, "finishing unit did not start")
  `RNR_ASSERT_NOW(a_done_in_calc, fin_done, bk_stat.calc, "root done outside the wait state")

endmodule

// File: rtl/rnr_front.sv
// Front end: accepts input words, takes magnitudes and tags each with its node.
// Depends on rnr_pkg.
module rnr_front import rnr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rnr_in_t          in_data,
  input  logic [EQS_W-1:0] eqs_per_node,
  input  logic             fifo_full,
  output logic             push,
  output rnr_item_t        push_item
);

  logic [EQ_W-1:0]   eq_cnt_r, eq_cnt_nxt;
  logic [NODE_W-1:0] node_cnt_r, node_cnt_nxt;
  logic [EQS_W-1:0]  eq_inc;
  logic              node_end;

  function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
  endfunction

  assign in_ready = !fifo_full;
  assign push     = in_valid && in_ready;

  assign eq_inc   = {1'b0, eq_cnt_r} + EQS_W'(1);
  assign node_end = eq_inc >= eff_eqs(eqs_per_node);

  always_comb begin
    push_item.ares = mag32(in_data.resid_value);
    push_item.ainc = mag32(in_data.incr_value);
    push_item.node = node_cnt_r;
    push_item.incl = in_data.node_included;
    push_item.bad  = in_data.resid_invalid;
    push_item.last = in_data.last_entry;
  end

  always_comb begin
    eq_cnt_nxt   = eq_cnt_r;
    node_cnt_nxt = node_cnt_r;
    if (push) begin
      if (in_data.last_entry) begin
        // The vector ends here, so the next word starts a fresh count.
        eq_cnt_nxt   = '0;
        node_cnt_nxt = '0;
      end else if (node_end) begin
        eq_cnt_nxt   = '0;
        node_cnt_nxt = node_cnt_r + NODE_W'(1);
      end else begin
        eq_cnt_nxt   = eq_inc[EQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eq_cnt_r   <= '0;
      node_cnt_r <= '0;
    end else begin
      eq_cnt_r   <= eq_cnt_nxt;
      node_cnt_r <= node_cnt_nxt;
    end
  end

endmodule

// File: rtl/rnr_fifo.sv
// Short queue of classified words between the front end and the accumulator.
// Depends on rnr_pkg.
module rnr_fifo import rnr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  rnr_item_t push_item,
  output logic      full,
  input  logic      pop,
  output rnr_item_t head,
  output logic      empty
);

  rnr_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;

  assign full  = count_r == FIFO_CW'(FIFO_DEPTH);
  assign empty = count_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      count_r <= count_r + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

endmodule

// File: rtl/rnr_finish.sv
// Iterative finishing unit: restoring divide of the square sum, then integer root.
// One quotient bit per cycle, then one root bit per cycle. Depends on rnr_pkg.
module rnr_finish import rnr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [DVS_W-1:0]  divisor,
  output logic              busy,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  rnr_fu_state_t      state_r, state_nxt;
  logic [SUM_W-1:0]   work_r;
  logic [SREM_W-1:0]  rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               done_r;

  logic [DREM_W-1:0]  div_sh, div_diff;
  logic               div_ge;
  logic [SREM_W-1:0]  sq_sh, sq_trial, sq_diff;
  logic               sq_ge;

  always_comb begin
    div_sh   = {rem_r[DVS_W-1:0], work_r[SUM_W-1]};
    div_ge   = div_sh >= {1'b0, dvs_r};
    div_diff = div_sh - {1'b0, dvs_r};
    sq_sh    = {rem_r[SREM_W-3:0], work_r[SUM_W-1:SUM_W-2]};
    sq_trial = {1'b0, root_r, 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    sq_diff  = sq_sh - sq_trial;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FU_IDLE: if (start) state_nxt = FU_DIV;
      FU_DIV:  if (cnt_r == '0) state_nxt = FU_ROOT;
      FU_ROOT: if (cnt_r == '0) state_nxt = FU_IDLE;
      default: state_nxt = FU_IDLE;
    endcase
  end

  always_comb begin
    busy = state_r != FU_IDLE;
    done = done_r;
    root = root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FU_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == FU_ROOT) && (cnt_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      FU_IDLE: begin
        if (start) begin
          work_r <= dividend;
          dvs_r  <= divisor;
          rem_r  <= '0;
          root_r <= '0;
          cnt_r  <= CNT_W'(DIV_STEPS - 1);
        end
      end
      FU_DIV: begin
        // The dividend register fills with quotient bits from the right.
        work_r <= {work_r[SUM_W-2:0], div_ge};
        if (cnt_r == '0) begin
          rem_r <= '0;
          cnt_r <= CNT_W'(ROOT_STEPS - 1);
        end else begin
          rem_r <= SREM_W'(div_ge ? div_diff : div_sh);
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
      FU_ROOT: begin
        work_r <= {work_r[SUM_W-3:0], 2'b00};
        rem_r  <= sq_ge ? sq_diff : sq_sh;
        root_r <= {root_r[ROOT_W-2:0], sq_ge};
        cnt_r  <= cnt_r - CNT_W'(1);
      end
      default: begin
        cnt_r <= '0;
      end
    endcase
  end

endmodule

// File: rtl/rnr_back.sv
// Back end: squares and accumulates words, tracks both maxima, drives the
// finishing unit and holds the result word. Depends on rnr_pkg.
module rnr_back import rnr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  rnr_item_t         head,
  input  logic              empty,
  output logic              pop,
  input  logic [EQS_W-1:0]  eqs_per_node,
  input  logic [TN_W-1:0]   total_nodes,
  output logic              fin_start,
  output logic [SUM_W-1:0]  fin_dividend,
  output logic [DVS_W-1:0]  fin_divisor,
  input  logic              fin_done,
  input  logic [ROOT_W-1:0] fin_root,
  output logic              out_valid,
  input  logic              out_ready,
  output rnr_out_t          out_data,
  output rnr_bk_stat_t      stat
);

  rnr_bk_state_t     state_r, state_nxt;
  logic [VAL_W-1:0]  best_resid_r, best_incr_r;
  logic [NODE_W-1:0] best_resid_node_r, best_incr_node_r;
  logic [SUM_W-1:0]  sum_r, sq_r;
  logic              sq_v_r;
  logic              invalid_r, overflow_r;
  rnr_out_t          hold_r, out_r, out_nxt;
  logic              out_valid_r;
  logic              out_load;
  logic [SUM_W:0]    sum_ext;
  logic [TN_W-1:0]   tn_eff;

  assign sum_ext      = {1'b0, sum_r} + {1'b0, sq_r};
  assign tn_eff       = (total_nodes == '0) ? TN_W'(1) : total_nodes;
  assign fin_dividend = sum_r;
  assign fin_divisor  = DVS_W'(tn_eff) * DVS_W'(eff_eqs(eqs_per_node));
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  always_comb begin
    out_nxt           = hold_r;
    out_nxt.rms_resid = fin_root;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_ACC:   if (!empty && head.last) state_nxt = BK_FLUSH;
      BK_FLUSH: state_nxt = BK_LATCH;
      BK_LATCH: state_nxt = BK_CALC;
      BK_CALC:  if (fin_done) state_nxt = BK_EMIT;
      BK_EMIT:  if (!out_valid_r || out_ready) state_nxt = BK_ACC;
      default:  state_nxt = BK_ACC;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    fin_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      BK_ACC:   pop = !empty;
      BK_LATCH: fin_start = 1'b1;
      BK_EMIT:  out_load = !out_valid_r || out_ready;
      default:  pop = 1'b0;
    endcase
    stat.calc = state_r == BK_CALC;
    stat.pop  = pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= BK_ACC;
      best_resid_r      <= '0;
      best_resid_node_r <= '0;
      best_incr_r       <= '0;
      best_incr_node_r  <= '0;
      sum_r             <= '0;
      sq_v_r            <= 1'b0;
      invalid_r         <= 1'b0;
      overflow_r        <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sq_v_r  <= pop && !head.bad;
      if (sq_v_r) begin
        if (sum_ext[SUM_W]) begin
          sum_r      <= '1;
          overflow_r <= 1'b1;
        end else begin
          sum_r <= sum_ext[SUM_W-1:0];
        end
      end
      if (pop) begin
        if (head.incl && (head.ainc > best_incr_r)) begin
          best_incr_r      <= head.ainc;
          best_incr_node_r <= head.node;
        end
        if (head.bad) begin
          invalid_r <= 1'b1;
        end else if (head.incl && (head.ares > best_resid_r)) begin
          best_resid_r      <= head.ares;
          best_resid_node_r <= head.node;
        end
      end
      if (state_r == BK_LATCH) begin
        // The totals are captured in the hold register; start the next vector clean.
        best_resid_r      <= '0;
        best_resid_node_r <= '0;
        best_incr_r       <= '0;
        best_incr_node_r  <= '0;
        sum_r             <= '0;
        invalid_r         <= 1'b0;
        overflow_r        <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sq_r <= SUM_W'(head.ares) * SUM_W'(head.ares);
    end
    if (state_r == BK_LATCH) begin
      hold_r.max_resid      <= best_resid_r;
      hold_r.max_resid_node <= best_resid_node_r;
      hold_r.max_incr       <= best_incr_r;
      hold_r.max_incr_node  <= best_incr_node_r;
      hold_r.rms_resid      <= '0;
      hold_r.invalid_seen   <= invalid_r;
      hold_r.sum_saturated  <= overflow_r;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

endmodule
